@@ hw/rtl/ssev_pkg.sv @@
// Shared types and constants for the sprite scanline evaluation block.
// Used by ssev_front, ssev_oam, ssev_back and sprite_scanline_evaluation.
`timescale 1ns / 1ps

package ssev_pkg;

    // Attribute memory geometry: 256 bytes in four byte-wide banks of 64 rows
    localparam int BANKS     = 4;
    localparam int ROW_W     = 6;
    localparam int MAX_OUT   = 8;

    localparam logic [7:0]  EMPTY_BYTE   = 8'hFF;
    localparam logic [7:0]  SHORT_HEIGHT = 8'h08;
    localparam logic [7:0]  TALL_HEIGHT  = 8'h10;
    localparam int          FLIP_BIT     = 7;
    localparam logic [5:0]  ROW_LAST     = 6'h3F;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [7:0]       byte_t;

    // Input item kinds
    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_kind_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_TALL_SPRITES = 1'b0,
        CFG_TABLE_HIGH   = 1'b1
    } cfg_reg_t;

    // One queued command
    typedef struct packed {
        cmd_kind_t  kind;
        byte_t      index;
        byte_t      data;
        logic [8:0] line;
    } cmd_t;

    // Queue control from the back part
    typedef struct packed {
        logic pop;
        logic hold;
    } front_ctrl_t;

    // Attribute memory write port
    typedef struct packed {
        logic [BANKS-1:0] en;
        row_t             row;
        byte_t            data;
    } oam_wr_t;

    // Attribute memory read port, one row per bank
    typedef struct packed {
        logic                   en;
        logic [BANKS-1:0][ROW_W-1:0] row;
    } oam_rd_t;

    // Back part sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

endpackage

@@ hw/rtl/ssev_front.sv @@
// Front part: accepts input beats, classifies them into commands and
// queues them for the back part. Depends on ssev_pkg.
`timescale 1ns / 1ps

module ssev_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [7:0]            oam_index,
    input  logic [7:0]            oam_data,
    input  logic [8:0]            line_number,
    input  ssev_pkg::front_ctrl_t ctrl,
    output logic                  cmd_valid,
    output ssev_pkg::cmd_t        cmd
);

    ssev_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    ssev_pkg::cmd_t cmd_in;
    logic           push;
    logic           pop;

    // Classify the incoming beat
    always_comb
    begin
        cmd_in.kind  = ssev_pkg::cmd_kind_t'(kind);
        cmd_in.index = oam_index;
        cmd_in.data  = oam_data;
        cmd_in.line  = line_number;
    end

    assign in_ready  = (cnt_reg != 2'd2) && !ctrl.hold;
    assign push      = in_valid && in_ready;
    assign pop       = ctrl.pop && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Store queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

@@ hw/rtl/ssev_oam.sv @@
// Sprite attribute memory: four byte-wide banks of 64 rows, one write port,
// one registered read of all four banks per cycle. Depends on ssev_pkg.
`timescale 1ns / 1ps

module ssev_oam
(
    input  logic                                  clk,
    input  ssev_pkg::oam_wr_t                     wr,
    input  ssev_pkg::oam_rd_t                     rd,
    output logic [ssev_pkg::BANKS-1:0][7:0]       rdata
);

    localparam int DEPTH = 1 << ssev_pkg::ROW_W;

    for (genvar b = 0; b < ssev_pkg::BANKS; b++)
    begin : g_bank
        logic [7:0] mem [DEPTH];

        // Write and read one bank
        always_ff @(posedge clk)
        begin
            if (wr.en[b])
            begin
                mem[wr.row] <= wr.data;
            end
            if (rd.en)
            begin
                rdata[b] <= mem[rd.row[b]];
            end
        end
    end

endmodule

@@ hw/rtl/ssev_back.sv @@
// Back part: clears the attribute memory after reset, carries out writes,
// scans entries into slots and emits one beat per slot.
// Depends on ssev_pkg; drives ssev_oam and pops ssev_front.
`timescale 1ns / 1ps

module ssev_back
#(
    parameter int SPRITE_COUNT = 64,
    parameter int SLOT_COUNT   = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    input  ssev_pkg::cmd_t                        cmd,
    output ssev_pkg::front_ctrl_t                 ctrl,
    input  logic                                  tall,
    input  logic                                  table_high,
    output ssev_pkg::oam_wr_t                     oam_wr,
    output ssev_pkg::oam_rd_t                     oam_rd,
    input  logic [ssev_pkg::BANKS-1:0][7:0]       oam_rdata,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [2:0]                            slot,
    output logic [12:0]                           pattern_addr,
    output logic [7:0]                            sprite_attr,
    output logic [7:0]                            sprite_x,
    output logic                                  overflow,
    output logic                                  last
);

    localparam int OUT_COUNT = (SLOT_COUNT < ssev_pkg::MAX_OUT) ? SLOT_COUNT
                                                                : ssev_pkg::MAX_OUT;
    localparam int NW  = $clog2(SPRITE_COUNT + 1);
    localparam int FW  = $clog2(SLOT_COUNT + 1);
    localparam int SIW = (OUT_COUNT > 1) ? $clog2(OUT_COUNT) : 1;

    ssev_pkg::back_state_t state_reg;
    ssev_pkg::back_state_t state_next;

    logic [NW-1:0]   issue_n_reg;
    logic            pend_reg;
    logic [1:0]      pend_m_reg;
    logic [1:0]      m_reg;
    logic [FW-1:0]   found_reg;
    logic [8:0]      line_reg;
    logic            overflow_reg;
    ssev_pkg::row_t  clr_row_reg;
    logic [SIW-1:0]  emit_reg;

    logic [7:0] slot_y_reg    [OUT_COUNT];
    logic [7:0] slot_tile_reg [OUT_COUNT];
    logic [7:0] slot_attr_reg [OUT_COUNT];
    logic [7:0] slot_x_reg    [OUT_COUNT];

    logic        out_valid_reg;
    logic [2:0]  slot_reg;
    logic [12:0] addr_reg;
    logic [7:0]  attr_o_reg;
    logic [7:0]  x_o_reg;
    logic        ovf_o_reg;
    logic        last_reg;

    // Scan datapath
    logic [7:0]  ent_y;
    logic [7:0]  ent_tile;
    logic [7:0]  ent_attr;
    logic [7:0]  ent_x;
    logic [7:0]  height;
    logic [9:0]  y_end;
    logic        hit;
    logic        full;
    logic        stop;
    logic        more;
    logic [1:0]  m_next;
    logic        slot_wr;

    // Control strobes
    logic        start_eval;
    logic        issue;
    logic        load;
    logic        emit_last;

    // Emit datapath
    logic [7:0]  e_y;
    logic [7:0]  e_tile;
    logic [7:0]  e_attr;
    logic [7:0]  off;
    logic [7:0]  off_f;
    logic [12:0] addr_calc;

    // Pick the entry bytes out of the rotated bank read
    always_comb
    begin
        ent_y    = oam_rdata[pend_m_reg];
        ent_tile = oam_rdata[2'(pend_m_reg + 2'd1)];
        ent_attr = oam_rdata[2'(pend_m_reg + 2'd2)];
        ent_x    = oam_rdata[2'(pend_m_reg + 2'd3)];
        height   = tall ? ssev_pkg::TALL_HEIGHT : ssev_pkg::SHORT_HEIGHT;
        y_end    = {2'b00, ent_y} + {2'b00, height};
        hit      = ({1'b0, line_reg} >= {2'b00, ent_y}) && ({1'b0, line_reg} < y_end);
        full     = (found_reg >= FW'(SLOT_COUNT));
        stop     = pend_reg && hit && full;
        more     = (issue_n_reg != NW'(SPRITE_COUNT));
        // Step the byte offset on each miss once the slots are full
        m_next   = (pend_reg && !hit && full) ? 2'(m_reg + 2'd1) : m_reg;
        slot_wr  = pend_reg && !full && (found_reg < FW'(OUT_COUNT));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssev_pkg::ST_CLEAR:
            begin
                if (clr_row_reg == ssev_pkg::ROW_LAST)
                begin
                    state_next = ssev_pkg::ST_IDLE;
                end
            end
            ssev_pkg::ST_IDLE:
            begin
                if (cmd_valid && (cmd.kind == ssev_pkg::CMD_EVAL))
                begin
                    state_next = ssev_pkg::ST_SCAN;
                end
            end
            ssev_pkg::ST_SCAN:
            begin
                if (stop || !more)
                begin
                    state_next = ssev_pkg::ST_EMIT;
                end
            end
            ssev_pkg::ST_EMIT:
            begin
                if (load && emit_last)
                begin
                    state_next = ssev_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssev_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs per state
    always_comb
    begin
        ctrl.pop    = 1'b0;
        ctrl.hold   = 1'b0;
        start_eval  = 1'b0;
        issue       = 1'b0;
        load        = 1'b0;
        oam_wr.en   = '0;
        oam_wr.row  = ssev_pkg::row_t'(cmd.index[7:2]);
        oam_wr.data = cmd.data;
        case (state_reg)
            ssev_pkg::ST_CLEAR:
            begin
                ctrl.hold   = 1'b1;
                oam_wr.en   = '1;
                oam_wr.row  = clr_row_reg;
                oam_wr.data = ssev_pkg::EMPTY_BYTE;
            end
            ssev_pkg::ST_IDLE:
            begin
                ctrl.pop = cmd_valid;
                if (cmd_valid && (cmd.kind == ssev_pkg::CMD_WRITE))
                begin
                    oam_wr.en = ssev_pkg::BANKS'(1) << cmd.index[1:0];
                end
                start_eval = cmd_valid && (cmd.kind == ssev_pkg::CMD_EVAL);
            end
            ssev_pkg::ST_SCAN:
            begin
                issue = !stop && more;
            end
            ssev_pkg::ST_EMIT:
            begin
                load = !out_valid_reg || out_ready;
            end
            default:
            begin
                ctrl.hold = 1'b0;
            end
        endcase
    end

    // Read address: entry n starts at byte 4n plus the current offset
    always_comb
    begin
        oam_rd.en = issue;
        for (int b = 0; b < ssev_pkg::BANKS; b++)
        begin
            oam_rd.row[b] = ssev_pkg::row_t'(issue_n_reg)
                          + ssev_pkg::row_t'((2'(b) < m_next) ? 1'b1 : 1'b0);
        end
    end

    assign emit_last = (emit_reg == SIW'(OUT_COUNT - 1));

    // Slot to result conversion
    always_comb
    begin
        e_y    = slot_y_reg[emit_reg];
        e_tile = slot_tile_reg[emit_reg];
        e_attr = slot_attr_reg[emit_reg];
        off    = 8'(line_reg[7:0] - e_y);
        off_f  = e_attr[ssev_pkg::FLIP_BIT] ? 8'(height - 8'd1 - off) : off;
        if (tall)
        begin
            addr_calc = {e_tile[0], e_tile[7:1], (off_f >= 8'd8), 1'b0, off_f[2:0]};
        end
        else
        begin
            addr_calc = {table_high, e_tile, 1'b0, off_f[2:0]};
        end
    end

    // Sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ssev_pkg::ST_CLEAR;
            clr_row_reg  <= '0;
            issue_n_reg  <= '0;
            pend_reg     <= 1'b0;
            pend_m_reg   <= 2'd0;
            m_reg        <= 2'd0;
            found_reg    <= '0;
            overflow_reg <= 1'b0;
            emit_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ssev_pkg::ST_CLEAR)
            begin
                clr_row_reg <= ssev_pkg::row_t'(clr_row_reg + 1'b1);
            end
            if (start_eval)
            begin
                issue_n_reg <= '0;
                pend_reg    <= 1'b0;
                m_reg       <= 2'd0;
                found_reg   <= '0;
            end
            else if (state_reg == ssev_pkg::ST_SCAN)
            begin
                pend_reg   <= issue;
                pend_m_reg <= m_next;
                m_reg      <= m_next;
                if (issue)
                begin
                    issue_n_reg <= NW'(issue_n_reg + 1'b1);
                end
                if (pend_reg && hit && !full)
                begin
                    found_reg <= FW'(found_reg + 1'b1);
                end
                if (stop)
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (load)
            begin
                emit_reg <= emit_last ? '0 : SIW'(emit_reg + 1'b1);
            end
        end
    end

    // Slot bytes and scanline
    always_ff @(posedge clk)
    begin
        if (start_eval)
        begin
            line_reg <= cmd.line;
            for (int i = 0; i < OUT_COUNT; i++)
            begin
                slot_y_reg[i]    <= ssev_pkg::EMPTY_BYTE;
                slot_tile_reg[i] <= ssev_pkg::EMPTY_BYTE;
                slot_attr_reg[i] <= ssev_pkg::EMPTY_BYTE;
                slot_x_reg[i]    <= ssev_pkg::EMPTY_BYTE;
            end
        end
        else if ((state_reg == ssev_pkg::ST_SCAN) && slot_wr)
        begin
            slot_y_reg[found_reg[SIW-1:0]] <= ent_y;
            if (hit)
            begin
                slot_tile_reg[found_reg[SIW-1:0]] <= ent_tile;
                slot_attr_reg[found_reg[SIW-1:0]] <= ent_attr;
                slot_x_reg[found_reg[SIW-1:0]]    <= ent_x;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg   <= 3'(emit_reg);
            addr_reg   <= addr_calc;
            attr_o_reg <= e_attr;
            x_o_reg    <= slot_x_reg[emit_reg];
            ovf_o_reg  <= overflow_reg;
            last_reg   <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot         = slot_reg;
    assign pattern_addr = addr_reg;
    assign sprite_attr  = attr_o_reg;
    assign sprite_x     = x_o_reg;
    assign overflow     = ovf_o_reg;
    assign last         = last_reg;

endmodule

@@ hw/rtl/sprite_scanline_evaluation.sv @@
// Sprite scanline evaluation: after reset the 256-byte attribute memory is
// filled with 0xFF row by row, and no input beat is taken until that pass
// ends. A write beat is then carried out by the back part from its idle
// state. An evaluate beat scans one entry per cycle through a four-bank
// memory that returns a whole four-byte entry per read, and then yields
// one result beat per slot. The scan stops early when the overflow entry
// is found. Up to two beats queue in front of the back part, and the
// result register lets the next beat be queued while a result waits.
// Depends on ssev_pkg and its modules.
`timescale 1ns / 1ps

module sprite_scanline_evaluation
#(
    parameter int SPRITE_COUNT = 64,
    parameter int SLOT_COUNT   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  oam_index,
    input  logic [7:0]  oam_data,
    input  logic [8:0]  line_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  slot,
    output logic [12:0] pattern_addr,
    output logic [7:0]  sprite_attr,
    output logic [7:0]  sprite_x,
    output logic        overflow,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic        cfg_data
);

    logic                                 tall_reg;
    logic                                 table_high_reg;
    ssev_pkg::front_ctrl_t                ctrl;
    logic                                 cmd_valid;
    ssev_pkg::cmd_t                       cmd;
    ssev_pkg::oam_wr_t                    oam_wr;
    ssev_pkg::oam_rd_t                    oam_rd;
    logic [ssev_pkg::BANKS-1:0][7:0]      oam_rdata;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tall_reg       <= 1'b0;
            table_high_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ssev_pkg::CFG_TALL_SPRITES)
            begin
                tall_reg <= cfg_data;
            end
            if (cfg_index == ssev_pkg::CFG_TABLE_HIGH)
            begin
                table_high_reg <= cfg_data;
            end
        end
    end

    ssev_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .oam_index   (oam_index),
        .oam_data    (oam_data),
        .line_number (line_number),
        .ctrl        (ctrl),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    ssev_oam u_oam
    (
        .clk   (clk),
        .wr    (oam_wr),
        .rd    (oam_rd),
        .rdata (oam_rdata)
    );

    ssev_back
    #(
        .SPRITE_COUNT (SPRITE_COUNT),
        .SLOT_COUNT   (SLOT_COUNT)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .ctrl         (ctrl),
        .tall         (tall_reg),
        .table_high   (table_high_reg),
        .oam_wr       (oam_wr),
        .oam_rd       (oam_rd),
        .oam_rdata    (oam_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .slot         (slot),
        .pattern_addr (pattern_addr),
        .sprite_attr  (sprite_attr),
        .sprite_x     (sprite_x),
        .overflow     (overflow),
        .last         (last)
    );

endmodule

@@ sim/sprite_scanline_evaluation_tb.sv @@
// Self-checking testbench for sprite_scanline_evaluation: drives attribute memory writes
// and scanline evaluations, predicts every slot result beat and checks it in order.
// Depends on ssev_pkg and the sprite_scanline_evaluation RTL.
`timescale 1ns / 1ps

module sprite_scanline_evaluation_tb;

    localparam int SPRITES       = 64;
    localparam int SLOTS         = 8;
    localparam int SLOT_BYTES    = SLOTS * 4;
    localparam int TABLE_STEP    = 'h1000;
    localparam int LOWER_TILE    = 'h10;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_CYCLES  = 600;
    localparam int IDLE_PERCENT  = 12;
    localparam int MAX_REPORTS   = 10;

    // One slot result beat as seen on the output port
    typedef struct packed {
        logic [2:0]       slot;
        logic [12:0]      addr;
        ssev_pkg::byte_t  attr;
        ssev_pkg::byte_t  x;
        logic             ovf;
        logic             last;
    } slot_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic [8:0]  line_number;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  slot;
    logic [12:0] pattern_addr;
    logic [7:0]  sprite_attr;
    logic [7:0]  sprite_x;
    logic        overflow;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic        cfg_data;

    // Shadow state of the block
    ssev_pkg::byte_t attr_shadow [256];
    logic            overflow_seen;
    logic            tall_mode;
    logic            table_high;
    slot_result_t    expected_slots [$];

    int unsigned  fail_count;
    int unsigned  stall_left;
    logic         steady;
    slot_result_t got_slot;
    slot_result_t want_slot;

    sprite_scanline_evaluation i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .oam_index    (oam_index),
        .oam_data     (oam_data),
        .line_number  (line_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .slot         (slot),
        .pattern_addr (pattern_addr),
        .sprite_attr  (sprite_attr),
        .sprite_x     (sprite_x),
        .overflow     (overflow),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Low-plane pattern address of one slot, vertical flip applied
    function automatic logic [12:0] low_plane_addr(logic [8:0] line, ssev_pkg::byte_t y,
                                                   ssev_pkg::byte_t tile,
                                                   ssev_pkg::byte_t attr);
        int height;
        int offset;
        int addr;
        height = tall_mode ? int'(ssev_pkg::TALL_HEIGHT) : int'(ssev_pkg::SHORT_HEIGHT);
        offset = (int'(line) - int'(y)) & 'hFF;
        if (attr[ssev_pkg::FLIP_BIT])
            offset = (height - offset - 1) & 'hFF;
        if (!tall_mode)
            addr = (table_high ? TABLE_STEP : 0) | (int'(tile) << 4) | (offset & 7);
        else
            addr = (tile[0] ? TABLE_STEP : 0) | ((int'(tile) & 'hFE) << 4) | (offset & 7)
                 | ((offset >= 8) ? LOWER_TILE : 0);
        return addr[12:0];
    endfunction

    // Scan the attribute memory for one line and queue the slot beats it yields
    function automatic void predict_line(logic [8:0] line);
        ssev_pkg::byte_t slot_bytes [SLOT_BYTES];
        int              found;
        int              skew;
        int              base;
        int              height;
        int              entry;
        int              s;
        ssev_pkg::byte_t y;
        logic            hit;
        logic            stop;
        slot_result_t    r;
        foreach (slot_bytes[b])
            slot_bytes[b] = ssev_pkg::EMPTY_BYTE;
        height = tall_mode ? int'(ssev_pkg::TALL_HEIGHT) : int'(ssev_pkg::SHORT_HEIGHT);
        found = 0;
        skew = 0;
        stop = 1'b0;
        for (entry = 0; entry < SPRITES && !stop; entry++)
        begin
            base = (skew + entry * 4) & 'hFF;
            y = attr_shadow[base];
            hit = (line >= y) && (int'(line) < int'(y) + height);
            // a miss still leaves its y byte in the first free slot
            if (found < SLOTS)
                slot_bytes[found * 4] = y;
            if (hit && found >= SLOTS)
            begin
                overflow_seen = 1'b1;
                stop = 1'b1;
            end
            else if (hit)
            begin
                slot_bytes[found * 4 + 1] = attr_shadow[(base + 1) & 'hFF];
                slot_bytes[found * 4 + 2] = attr_shadow[(base + 2) & 'hFF];
                slot_bytes[found * 4 + 3] = attr_shadow[(base + 3) & 'hFF];
                found++;
            end
            else if (found >= SLOTS)
                // slots full: each miss also walks the byte offset (diagonal read)
                skew = (skew + 1) & 3;
        end
        for (s = 0; s < SLOTS; s++)
        begin
            r.slot = s[2:0];
            r.addr = low_plane_addr(line, slot_bytes[s * 4], slot_bytes[s * 4 + 1],
                                    slot_bytes[s * 4 + 2]);
            r.attr = slot_bytes[s * 4 + 2];
            r.x    = slot_bytes[s * 4 + 3];
            r.ovf  = overflow_seen;
            r.last = (s == SLOTS - 1);
            expected_slots.push_back(r);
        end
    endfunction

    // Offer one beat, hold it until taken, then update the shadow state
    task automatic send_item(ssev_pkg::cmd_kind_t k, ssev_pkg::byte_t idx,
                             ssev_pkg::byte_t val, logic [8:0] line);
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        oam_index   <= idx;
        oam_data    <= val;
        line_number <= line;
        do
            @(posedge clk);
        while (!in_ready);
        if (k == ssev_pkg::CMD_WRITE)
            attr_shadow[idx] = val;
        else
            predict_line(line);
    endtask

    // Drop the input and hold until every pending result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(logic tall, logic high);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= ssev_pkg::CFG_TALL_SPRITES;
        cfg_data  <= tall;
        do
            @(posedge clk);
        while (!cfg_ready);
        tall_mode = tall;
        cfg_index <= ssev_pkg::CFG_TABLE_HIGH;
        cfg_data  <= high;
        do
            @(posedge clk);
        while (!cfg_ready);
        table_high = high;
        cfg_valid <= 1'b0;
    endtask

    task automatic write_entry(int entry, ssev_pkg::byte_t y, ssev_pkg::byte_t tile,
                               ssev_pkg::byte_t attr, ssev_pkg::byte_t x);
        send_item(ssev_pkg::CMD_WRITE, ssev_pkg::byte_t'(entry * 4),     y,    9'($urandom));
        send_item(ssev_pkg::CMD_WRITE, ssev_pkg::byte_t'(entry * 4 + 1), tile, 9'($urandom));
        send_item(ssev_pkg::CMD_WRITE, ssev_pkg::byte_t'(entry * 4 + 2), attr, 9'($urandom));
        send_item(ssev_pkg::CMD_WRITE, ssev_pkg::byte_t'(entry * 4 + 3), x,    9'($urandom));
    endtask

    task automatic evaluate(logic [8:0] line);
        send_item(ssev_pkg::CMD_EVAL, ssev_pkg::byte_t'($urandom),
                  ssev_pkg::byte_t'($urandom), line);
    endtask

    // 8x8 sprites: flip, plain entry, stale y in the empty slots
    task automatic test_short_sprites();
        load_config(1'b0, 1'b0);
        write_entry(0, 8'h00, 8'hFF, 8'h80, 8'hFF);
        write_entry(1, 8'h05, 8'h01, 8'h23, 8'h00);
        evaluate(9'd5);
        evaluate(9'd0);
    endtask

    // 8x16 sprites: tile bit 0 picks the table, offset bit 3 picks the lower tile
    task automatic test_tall_sprites();
        load_config(1'b1, 1'b1);
        evaluate(9'd12);
        evaluate(9'd20);
    endtask

    // Highest byte address and the ends of the line range
    task automatic test_line_extremes();
        load_config(1'b0, 1'b1);
        send_item(ssev_pkg::CMD_WRITE, 8'hFF, 8'h00, 9'h1FF);
        evaluate(9'h1FF);
        evaluate(9'd0);
    endtask

    // Nine hits with misses after the slots fill: the skewed reads find the overflow
    task automatic test_overflow_skew();
        load_config(1'b0, 1'b0);
        send_item(ssev_pkg::CMD_WRITE, 8'd40, 8'h00, 9'd0);
        send_item(ssev_pkg::CMD_WRITE, 8'd45, 8'h00, 9'd0);
        evaluate(9'd256);
    endtask

    // Stall the receiver while evaluations keep coming, so the input backs up
    task automatic test_backpressure();
        stall_left = STALL_CYCLES;
        repeat (6)
            evaluate(9'($urandom_range(0, 261)));
        wait_for_results();
    endtask

    // Mostly sprites placed around a chosen line then its evaluation, some noise
    task automatic run_random_phase(logic tall, logic high, int unsigned items);
        int unsigned     sent;
        int              entry;
        int              span;
        logic [8:0]      line;
        ssev_pkg::byte_t y;
        load_config(tall, high);
        sent = 0;
        span = tall ? 17 : 9;
        while (sent < items)
        begin
            if ($urandom_range(99) < 80)
            begin
                line = ($urandom_range(9) == 0) ? 9'($urandom_range(262, 511))
                                                : 9'($urandom_range(0, 261));
                repeat ($urandom_range(1, 10))
                begin
                    entry = $urandom_range(0, SPRITES - 1);
                    y = ssev_pkg::byte_t'(int'(line) - $urandom_range(0, span));
                    if ($urandom_range(99) < 30)
                    begin
                        write_entry(entry, y, ssev_pkg::byte_t'($urandom),
                                    ssev_pkg::byte_t'($urandom),
                                    ssev_pkg::byte_t'($urandom));
                        sent += 4;
                    end
                    else
                    begin
                        send_item(ssev_pkg::CMD_WRITE, ssev_pkg::byte_t'(entry * 4), y,
                                  9'($urandom));
                        sent++;
                    end
                end
                evaluate(line);
                sent++;
            end
            else
            begin
                send_item(ssev_pkg::cmd_kind_t'($urandom_range(0, 1)),
                          ssev_pkg::byte_t'($urandom), ssev_pkg::byte_t'($urandom),
                          9'($urandom));
                sent++;
            end
        end
    endtask

    // Result side: random stalls, a long hold when asked
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (!steady && $urandom_range(99) < IDLE_PERCENT)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_slot = {slot, pattern_addr, sprite_attr, sprite_x, overflow, last};
            if (expected_slots.size() == 0)
                note_failure($sformatf("unexpected result beat: slot %0d addr %h",
                                       slot, pattern_addr));
            else
            begin
                want_slot = expected_slots.pop_front();
                if (got_slot.slot !== want_slot.slot || got_slot.addr !== want_slot.addr
                    || got_slot.attr !== want_slot.attr || got_slot.x !== want_slot.x
                    || got_slot.ovf !== want_slot.ovf || got_slot.last !== want_slot.last)
                    note_failure({
                        $sformatf("mismatch: expected slot %0d addr %h attr %h x %h",
                                  want_slot.slot, want_slot.addr, want_slot.attr,
                                  want_slot.x),
                        $sformatf(" ovf %b last %b, got slot %0d addr %h attr %h x %h",
                                  want_slot.ovf, want_slot.last, got_slot.slot,
                                  got_slot.addr, got_slot.attr, got_slot.x),
                        $sformatf(" ovf %b last %b", got_slot.ovf, got_slot.last)});
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = ssev_pkg::CMD_WRITE;
        oam_index   = '0;
        oam_data    = '0;
        line_number = '0;
        cfg_valid   = 1'b0;
        cfg_index   = ssev_pkg::CFG_TALL_SPRITES;
        cfg_data    = 1'b0;
        steady      = 1'b0;
        stall_left  = 0;
        fail_count  = 0;
        foreach (attr_shadow[a])
            attr_shadow[a] = ssev_pkg::EMPTY_BYTE;
        overflow_seen = 1'b0;
        tall_mode     = 1'b0;
        table_high    = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_sprites();
        test_tall_sprites();
        test_line_extremes();
        test_overflow_skew();
        test_backpressure();
        run_random_phase(1'b1, 1'b0, 20);
        steady = 1'b1;
        run_random_phase(1'b0, 1'b0, 20);
        steady = 1'b0;
        run_random_phase(1'b1, 1'b1, 20);
        run_random_phase(1'b0, 1'b1, 20);
        wait_for_results();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ssev_pkg.sv
hw/rtl/ssev_front.sv
hw/rtl/ssev_oam.sv
hw/rtl/ssev_back.sv
hw/rtl/sprite_scanline_evaluation.sv
sim/sprite_scanline_evaluation_tb.sv
